// ===== src/lpmbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmbt_pkg
// Shared types and constants for the binary trie longest-prefix-match engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmbt_pkg;

    // Sizing of the node pool and the route store
    localparam int NODE_COUNT    = 65536;
    localparam int ROUTE_ID_BITS = 16;
    localparam int ADDR_BITS     = 32;

    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int USED_BITS  = $clog2(NODE_COUNT + 1);
    localparam int DEPTH_BITS = $clog2(ADDR_BITS + 1);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Input item
    typedef struct packed {
        logic        command;
        logic [31:0] prefix;
        logic [5:0]  prefix_len;
        logic [15:0] route_id;
        logic [31:0] lookup_addr;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic        found;
        logic [15:0] match_id;
        logic        pool_full;
    } out_item_t;

    // One trie node as held in the pool
    typedef struct packed {
        logic [NODE_BITS-1:0]     left_child;
        logic [NODE_BITS-1:0]     right_child;
        logic                     route_valid;
        logic [ROUTE_ID_BITS-1:0] route_id;
    } node_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/lpmbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmbt_ctrl
// Sequencer: takes an item, then steps the datapath one trie level a cycle
// until the walk ends and the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmbt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpmbt_pkg::dp_stat_t  dp_stat,
    output lpmbt_pkg::ctl_cmd_t  ctl_cmd
);
    import lpmbt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        ctl_cmd.load = 1'b0;
        ctl_cmd.step = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl_cmd.load = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK: begin
                // final level waits until the result register can take the item
                if (!(dp_stat.last && dp_stat.out_busy)) begin
                    ctl_cmd.step = 1'b1;
                    if (dp_stat.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lpmbt_dpath.sv =====
// ----------------------------------------------------------------------------
// lpmbt_dpath
// Node pool, root node, walk registers and result register. Each step
// evaluates one node and either follows a child, allocates one, or finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmbt_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpmbt_pkg::in_item_t   s_item,
    input  lpmbt_pkg::ctl_cmd_t   ctl_cmd,
    output lpmbt_pkg::dp_stat_t   dp_stat,
    output lpmbt_pkg::out_item_t  m_item,
    output logic                  m_valid,
    input  logic                  m_ready
);
    import lpmbt_pkg::*;

    // Node pool (root lives in flops, entry 0 of the memory is never used)
    node_t mem [NODE_COUNT];

    node_t                    root_reg;
    node_t                    rdata_reg;
    logic [USED_BITS-1:0]     used_reg;

    // Walk state
    logic                     cmd_reg;
    logic [ADDR_BITS-1:0]     key_reg;
    logic [DEPTH_BITS-1:0]    len_reg;
    logic [DEPTH_BITS-1:0]    depth_reg;
    logic [ROUTE_ID_BITS-1:0] id_reg;
    logic [NODE_BITS-1:0]     node_reg;
    logic                     fresh_reg;
    logic                     best_valid_reg;
    logic [ROUTE_ID_BITS-1:0] best_id_reg;

    // Result register
    logic                     m_valid_reg;
    out_item_t                m_item_reg;

    node_t                    cur;
    node_t                    wr_word;
    logic                     key_bit;
    logic [NODE_BITS-1:0]     child;
    logic [NODE_BITS-1:0]     new_idx;
    logic                     child_none;
    logic                     depth_end;
    logic                     ins_done;
    logic                     pool_empty;
    logic                     last;
    logic                     follow;
    logic                     alloc;
    logic                     wr_node;
    logic                     full;
    logic                     hit;
    logic                     mem_wr;
    logic                     rd_en;
    out_item_t                res;

    // Current node: fresh nodes are known clear, root from flops
    always_comb begin
        if (fresh_reg) begin
            cur = '0;
        end else if (node_reg == '0) begin
            cur = root_reg;
        end else begin
            cur = rdata_reg;
        end
    end

    assign key_bit    = key_reg[ADDR_BITS-1];
    assign child      = key_bit ? cur.right_child : cur.left_child;
    assign child_none = (child == '0);
    assign depth_end  = (depth_reg == DEPTH_BITS'(ADDR_BITS));
    assign ins_done   = (depth_reg == len_reg);
    assign pool_empty = (used_reg >= USED_BITS'(NODE_COUNT));
    assign new_idx    = used_reg[NODE_BITS-1:0];
    assign hit        = cur.route_valid;

    // Per-level decision
    always_comb begin
        last    = 1'b0;
        follow  = 1'b0;
        alloc   = 1'b0;
        wr_node = 1'b0;
        full    = 1'b0;
        wr_word = cur;
        if (cmd_reg == CMD_LOOKUP) begin
            last   = depth_end || child_none;
            follow = !last;
        end else if (ins_done) begin
            last                = 1'b1;
            wr_node             = 1'b1;
            wr_word.route_valid = 1'b1;
            wr_word.route_id    = id_reg;
        end else if (!child_none) begin
            follow = 1'b1;
        end else if (pool_empty) begin
            // stop; a node allocated by this insert still has to be cleared
            last    = 1'b1;
            full    = 1'b1;
            wr_node = fresh_reg;
        end else begin
            alloc   = 1'b1;
            wr_node = 1'b1;
            if (key_bit) begin
                wr_word.right_child = new_idx;
            end else begin
                wr_word.left_child = new_idx;
            end
        end
    end

    // Result of the finishing step
    always_comb begin
        res.pool_full = full;
        if (cmd_reg == CMD_LOOKUP) begin
            res.found    = hit || best_valid_reg;
            res.match_id = hit ? 16'(cur.route_id) : 16'(best_id_reg);
        end else begin
            res.found    = 1'b0;
            res.match_id = '0;
        end
    end

    assign mem_wr = ctl_cmd.step && wr_node && (node_reg != '0);
    assign rd_en  = ctl_cmd.step && follow;

    // Pool memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[node_reg] <= wr_word;
        end
        if (rd_en) begin
            rdata_reg <= mem[child];
        end
    end

    // Root node, allocation count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            used_reg    <= USED_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl_cmd.step && wr_node && (node_reg == '0)) begin
                root_reg <= wr_word;
            end
            if (ctl_cmd.step && alloc) begin
                used_reg <= used_reg + USED_BITS'(1);
            end
            if (ctl_cmd.step && last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        if (ctl_cmd.load) begin
            cmd_reg        <= s_item.command;
            key_reg        <= (s_item.command == CMD_LOOKUP) ? s_item.lookup_addr
                                                             : s_item.prefix;
            len_reg        <= (s_item.prefix_len > 6'(ADDR_BITS)) ? DEPTH_BITS'(ADDR_BITS)
                                                                  : DEPTH_BITS'(s_item.prefix_len);
            id_reg         <= ROUTE_ID_BITS'(s_item.route_id);
            depth_reg      <= '0;
            node_reg       <= '0;
            fresh_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            best_id_reg    <= '0;
        end else if (ctl_cmd.step && !last) begin
            key_reg   <= key_reg << 1;
            depth_reg <= depth_reg + DEPTH_BITS'(1);
            node_reg  <= alloc ? new_idx : child;
            fresh_reg <= fresh_reg || alloc;
            if (hit) begin
                best_valid_reg <= 1'b1;
                best_id_reg    <= cur.route_id;
            end
        end
        if (ctl_cmd.step && last) begin
            m_item_reg <= res;
        end
    end

    assign dp_stat.last     = last;
    assign dp_stat.out_busy = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_item           = m_item_reg;

endmodule

`default_nettype wire

// ===== src/lpm_binary_trie.sv =====
// ----------------------------------------------------------------------------
// lpm_binary_trie
// IPv4 longest-prefix-match engine on a one-bit-per-level binary trie.
// ----------------------------------------------------------------------------
//  channel   ports                    item
//  s_        s_valid/s_ready/s_item   insert or lookup command
//  m_        m_valid/m_ready/m_item   found, match id, pool full
//
//  An item is accepted, then the walk steps once per trie level visited (up
//  to 33), bound by the single registered read of the node pool.
//  Reset clears the root node and the allocation count; no clearing pass.
//  The next item is taken while a result waits in the output register; a
//  walk holds on its final level while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_binary_trie (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lpmbt_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lpmbt_pkg::out_item_t  m_item
);
    import lpmbt_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    lpmbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_stat (dp_stat),
        .ctl_cmd (ctl_cmd)
    );

    lpmbt_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .ctl_cmd (ctl_cmd),
        .dp_stat (dp_stat),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    // An accepted item closes the input in the cycle after the accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.load |=> !s_ready)
        else $error("input reopened straight after accept");

    // Loading and stepping never coincide
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl_cmd.load && ctl_cmd.step))
        else $error("load and step in the same cycle");

    // A finishing step always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_cmd.step && dp_stat.last) |=> m_valid)
        else $error("finished walk produced no result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lpm_binary_trie. A directed table covers the empty
// trie, the default route, full-length routes, overwrites, prefix lengths
// above 32 and ignored low prefix bits. Random nested routes and lookups run
// next, under random sender gaps and receiver stalls, with a final stretch
// run without idling. Results are checked against the table or a trie model kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lpmbt_pkg::*;

    localparam int TOP_BIT      = ADDR_BITS - 1;
    localparam int RANDOM_ITEMS = 500;
    localparam int SEGMENT      = 50;
    localparam int SETTLE       = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Trie model: child links, route per node, allocation count
    logic [NODE_BITS-1:0]   trie_left  [NODE_COUNT];
    logic [NODE_BITS-1:0]   trie_right [NODE_COUNT];
    logic [ROUTE_ID_BITS:0] trie_route [NODE_COUNT];
    int unsigned            trie_used;

    out_item_t   result_q[$];
    stim_row_t   dir_rows[$];
    logic [31:0] route_pfx[$];
    int unsigned route_len[$];

    int unsigned bad_count;
    int unsigned insert_count;
    int unsigned full_count;
    int unsigned lookup_count;
    int unsigned hit_count;
    bit          sender_gaps;
    bit          receiver_stalls;

    lpm_binary_trie dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #1 aclk = ~aclk;
    end

    // High bits kept by a prefix of the given length
    function automatic logic [31:0] len_mask(input int unsigned len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // Walk the model trie for one item; inserts update it
    function automatic out_item_t lpm_predict(input in_item_t it);
        out_item_t              res;
        int unsigned            node;
        int unsigned            nxt;
        int unsigned            depth;
        int unsigned            len;
        logic                   b;
        logic [ROUTE_ID_BITS:0] r;
        res = '0;
        node = 0;
        if (it.command == CMD_INSERT) begin
            len = (it.prefix_len > ADDR_BITS) ? ADDR_BITS : it.prefix_len;
            for (depth = 0; depth < len; depth++) begin
                b = it.prefix[TOP_BIT - depth];
                nxt = b ? trie_right[node] : trie_left[node];
                if (nxt == 0) begin
                    // pool exhausted: nodes already taken stay, no route
                    if (trie_used >= NODE_COUNT) begin
                        res.pool_full = 1'b1;
                        return res;
                    end
                    nxt = trie_used;
                    trie_used++;
                    trie_left[nxt]  = '0;
                    trie_right[nxt] = '0;
                    trie_route[nxt] = '0;
                    if (b)
                        trie_right[node] = NODE_BITS'(nxt);
                    else
                        trie_left[node] = NODE_BITS'(nxt);
                end
                node = nxt;
            end
            trie_route[node] = {1'b1, it.route_id};
        end else begin
            for (depth = 0; depth <= ADDR_BITS; depth++) begin
                r = trie_route[node];
                if (r[ROUTE_ID_BITS]) begin
                    res.found    = 1'b1;
                    res.match_id = r[ROUTE_ID_BITS-1:0];
                end
                if (depth == ADDR_BITS)
                    break;
                b = it.lookup_addr[TOP_BIT - depth];
                node = b ? trie_right[node] : trie_left[node];
                if (node == 0)
                    break;
            end
        end
        return res;
    endfunction

    function automatic void add_row(input logic cmd, input logic [31:0] pfx,
                                    input logic [5:0] len, input logic [15:0] id,
                                    input logic [31:0] addr, input int typed,
                                    input int fnd, input logic [15:0] mid,
                                    input int pf);
        stim_row_t row;
        row.item.command     = cmd;
        row.item.prefix      = pfx;
        row.item.prefix_len  = len;
        row.item.route_id    = id;
        row.item.lookup_addr = addr;
        row.typed            = (typed != 0);
        row.want.found       = (fnd != 0);
        row.want.match_id    = mid;
        row.want.pool_full   = (pf != 0);
        dir_rows.push_back(row);
    endfunction

    // Random item: mostly routes nested under known ones and lookups near them
    function automatic in_item_t make_item();
        in_item_t    it;
        int unsigned k;
        int unsigned blen;
        logic [31:0] m;
        it.command     = ($urandom_range(0, 9) < 4) ? CMD_INSERT : CMD_LOOKUP;
        it.prefix      = $urandom;
        it.route_id    = 16'($urandom);
        it.lookup_addr = $urandom;
        it.prefix_len  = 6'(($urandom_range(0, 5) == 0) ? $urandom_range(33, 63)
                                                        : $urandom_range(0, 32));
        if (route_pfx.size() != 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, route_pfx.size() - 1);
            blen = route_len[k];
            m = len_mask(blen);
            if (it.command == CMD_INSERT) begin
                it.prefix = (route_pfx[k] & m) | (it.prefix & ~m);
                if ($urandom_range(0, 5) != 0)
                    it.prefix_len = 6'($urandom_range(blen, ADDR_BITS));
            end else begin
                it.lookup_addr = (route_pfx[k] & m) | (it.lookup_addr & ~m);
            end
        end
        if (it.command == CMD_INSERT) begin
            route_pfx.push_back(it.prefix);
            route_len.push_back((it.prefix_len > ADDR_BITS) ? ADDR_BITS
                                                            : it.prefix_len);
        end
        return it;
    endfunction

    // Offer one item, hold it until taken, then queue what it should return
    task automatic push_item(input in_item_t it, input bit typed,
                             input out_item_t want);
        out_item_t res;
        @(negedge aclk);
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        res = lpm_predict(it);
        result_q.push_back(typed ? want : res);
        if (it.command == CMD_INSERT) begin
            insert_count++;
            full_count += res.pool_full;
        end else begin
            lookup_count++;
            hit_count += res.found;
        end
    endtask

    task automatic send(input in_item_t it);
        push_item(it, 1'b0, '0);
    endtask

    task automatic hold_off(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1)
            @(negedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("%0t: unexpected result found=%0b id=%h full=%0b",
                             $realtime, m_item.found, m_item.match_id,
                             m_item.pool_full);
            end else begin
                if (m_item.found !== result_q[0].found ||
                    m_item.match_id !== result_q[0].match_id ||
                    m_item.pool_full !== result_q[0].pool_full) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp found=%0b id=%h full=%0b %s",
                                 $realtime, result_q[0].found,
                                 result_q[0].match_id, result_q[0].pool_full,
                                 $sformatf("got found=%0b id=%h full=%0b",
                                           m_item.found, m_item.match_id,
                                           m_item.pool_full));
                end
                void'(result_q.pop_front());
            end
        end
    end

    // Receiver: random stall bursts while enabled, otherwise always ready
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1)
                    @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1)
                    @(negedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Main sequence
    initial begin
        in_item_t    it;
        int unsigned n;
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_item          = '0;
        m_ready         = 1'b0;
        bad_count       = 0;
        insert_count    = 0;
        full_count      = 0;
        lookup_count    = 0;
        hit_count       = 0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        trie_left[0]    = '0;
        trie_right[0]   = '0;
        trie_route[0]   = '0;
        trie_used       = 1;

        repeat (5)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows: empty trie, default route, extremes
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h0000_0000, 1, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 16'h0,    0);
        add_row(CMD_INSERT, 32'hDEAD_BEEF, 6'd0,  16'h1234, 32'hFFFF_FFFF, 1, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hFFFF_FFFF, 1, 1, 16'h1234, 0);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 32'h0,         1, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hFFFF_FFFF, 1, 1, 16'hFFFF, 0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hFFFF_FFFE, 1, 1, 16'h1234, 0);
        add_row(CMD_INSERT, 32'h0000_0000, 6'd32, 16'h0000, 32'h0,         1, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 32'h0000_0000, 1, 1, 16'h0000, 0);
        // ignored bits below the prefix length, nested routes, overwrite
        add_row(CMD_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h00A1, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hC0A8_1234, 0, 0, 16'h0,    0);
        add_row(CMD_INSERT, 32'hC0A8_01AB, 6'd24, 16'h00A2, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hC0A8_0105, 0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hC0A8_0205, 0, 0, 16'h0,    0);
        add_row(CMD_INSERT, 32'hC0A8_0100, 6'd24, 16'h00A3, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'hC0A8_01FF, 0, 0, 16'h0,    0);
        // prefix lengths above 32 count as 32
        add_row(CMD_INSERT, 32'h0A00_0001, 6'd63, 16'h5555, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h0A00_0001, 0, 0, 16'h0,    0);
        add_row(CMD_INSERT, 32'h0A00_0002, 6'd33, 16'hAAAA, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h0A00_0002, 0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h0A00_0003, 0, 0, 16'h0,    0);
        add_row(CMD_INSERT, 32'h8000_0000, 6'd1,  16'h8001, 32'h0,         0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h7FFF_FFFF, 0, 0, 16'h0,    0);
        add_row(CMD_LOOKUP, 32'h0,         6'd0,  16'h0,    32'h8000_0000, 0, 0, 16'h0,    0);

        foreach (dir_rows[i]) begin
            push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            if (dir_rows[i].item.command == CMD_INSERT) begin
                route_pfx.push_back(dir_rows[i].item.prefix);
                route_len.push_back((dir_rows[i].item.prefix_len > ADDR_BITS)
                                    ? ADDR_BITS : dir_rows[i].item.prefix_len);
            end
        end
        drain_results();

        // Random routes and lookups; idling switched per segment, none at the end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT == 0) begin
                if (n + SEGMENT >= RANDOM_ITEMS) begin
                    sender_gaps     = 1'b0;
                    receiver_stalls = 1'b0;
                end else begin
                    sender_gaps     = ($urandom_range(0, 3) != 0);
                    receiver_stalls = ($urandom_range(0, 3) != 0);
                end
            end
            if (sender_gaps && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 15));
            it = make_item();
            send(it);
        end

        drain_results();
        repeat (SETTLE)
            @(posedge aclk);

        $display("covered %0d inserts (%0d refused on a full pool), %0d lookups (%0d hit)",
                 insert_count, full_count, lookup_count, hit_count);
        $display("trie grew to %0d nodes; %0d mismatches seen", trie_used, bad_count);
        if (bad_count == 0 && result_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
